>>> hw/rtl/sswq_pkg.sv
// Package: widths, constants and shared types of the sorted sleep/wake-up queue.
`default_nettype none
package sswq_pkg;

  localparam int IdW         = 8;
  localparam int DurW        = 32;
  localparam int TickW       = 63;
  localparam int MaxSleepers = 16;
  localparam int MaxResults  = 16;
  localparam int CntW        = $clog2(MaxSleepers + 1);
  localparam int PopW        = $clog2(MaxResults);

  localparam logic CmdTick  = 1'b0;
  localparam logic CmdSleep = 1'b1;

  localparam logic KindWoken  = 1'b0;
  localparam logic KindReject = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StDeadline,
    StInsert,
    StReject,
    StTick,
    StPop
  } sswq_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic calc_deadline;
    logic insert;
    logic inc_tick;
    logic pop_emit;
    logic reject_emit;
  } sswq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic head_due;
    logic last_pop;
    logic out_free;
  } sswq_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/sswq_in_if.sv
// Interface: input word channel (tick or sleep request).
`default_nettype none
interface sswq_in_if;
  import sswq_pkg::*;

  logic            valid;
  logic            ready;
  logic            cmd;
  logic [IdW-1:0]  sleeper_id;
  logic [DurW-1:0] sleep_ticks;

  modport source (output valid, cmd, sleeper_id, sleep_ticks, input ready);
  modport sink   (input valid, cmd, sleeper_id, sleep_ticks, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sswq_out_if.sv
// Interface: result word channel (wake-up or reject report).
`default_nettype none
interface sswq_out_if;
  import sswq_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [IdW-1:0]   woken_id;
  logic [TickW-1:0] tick_now;
  logic             last;

  modport source (output valid, kind, woken_id, tick_now, last, input ready);
  modport sink   (input valid, kind, woken_id, tick_now, last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/sswq_ctrl.sv
// Controller: sequences accept, deadline, insert, reject, tick and pop steps.
`default_nettype none
module sswq_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_cmd_i,
  output logic                       in_ready_o,
  input  wire sswq_pkg::sswq_status_t status_i,
  output sswq_pkg::sswq_cmd_t        cmd_o
);
  import sswq_pkg::*;

  sswq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          if (in_cmd_i == CmdSleep) begin
            state_d = status_i.full ? StReject : StDeadline;
          end else begin
            state_d = StTick;
          end
        end
      end
      StDeadline: begin
        cmd_o.calc_deadline = 1'b1;
        state_d             = StInsert;
      end
      StInsert: begin
        cmd_o.insert = 1'b1;
        state_d      = StIdle;
      end
      StReject: begin
        if (status_i.out_free) begin
          cmd_o.reject_emit = 1'b1;
          state_d           = StIdle;
        end
      end
      StTick: begin
        cmd_o.inc_tick = 1'b1;
        state_d        = StPop;
      end
      StPop: begin
        if (!status_i.head_due) begin
          state_d = StIdle;
        end else if (status_i.out_free) begin
          cmd_o.pop_emit = 1'b1;
          if (status_i.last_pop) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/sswq_datapath.sv
// Datapath: tick counter, sorted shift-register queue and output register.
`default_nettype none
module sswq_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sswq_pkg::sswq_cmd_t       cmd_i,
  output sswq_pkg::sswq_status_t         status_o,
  input  wire logic [sswq_pkg::IdW-1:0]  req_id_i,
  input  wire logic [sswq_pkg::DurW-1:0] req_dur_i,
  input  wire logic                      out_ready_i,
  output logic                           out_valid_o,
  output logic                           out_kind_o,
  output logic [sswq_pkg::IdW-1:0]       out_id_o,
  output logic [sswq_pkg::TickW-1:0]     out_tick_o,
  output logic                           out_last_o
);
  import sswq_pkg::*;

  logic [TickW-1:0] tick_q;
  logic [CntW-1:0]  count_q;
  logic [PopW-1:0]  pop_cnt_q;
  logic             out_valid_q;

  logic [TickW-1:0] entry_dl_q [MaxSleepers];
  logic [IdW-1:0]   entry_id_q [MaxSleepers];
  logic [IdW-1:0]   req_id_q;
  logic [DurW-1:0]  req_dur_q;
  logic [TickW-1:0] deadline_q;

  logic [TickW:0]       dl_sum;
  logic [MaxSleepers-1:0] le;
  logic                 next_due;
  logic                 emit;

  assign dl_sum = {1'b0, tick_q} + {{(TickW + 1 - DurW){1'b0}}, req_dur_q};

  // entries at or before the new deadline form a prefix of the queue
  always_comb begin
    for (int i = 0; i < MaxSleepers; i++) begin
      le[i] = (CntW'(i) < count_q) && (entry_dl_q[i] <= deadline_q);
    end
  end

  assign next_due = (count_q > CntW'(1)) && (entry_dl_q[1] <= tick_q);
  assign emit     = cmd_i.pop_emit || cmd_i.reject_emit;

  assign status_o.full     = (count_q == CntW'(MaxSleepers));
  assign status_o.head_due = (count_q != '0) && (entry_dl_q[0] <= tick_q);
  assign status_o.last_pop = (pop_cnt_q == PopW'(MaxResults - 1)) || !next_due;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      count_q     <= '0;
      pop_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.inc_tick) begin
        tick_q    <= tick_q + TickW'(1);
        pop_cnt_q <= '0;
      end
      if (cmd_i.insert) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.pop_emit) begin
        count_q   <= count_q - CntW'(1);
        pop_cnt_q <= pop_cnt_q + PopW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_id_q  <= req_id_i;
      req_dur_q <= req_dur_i;
    end
    if (cmd_i.calc_deadline) begin
      // saturate at the top of the tick range
      deadline_q <= dl_sum[TickW] ? {TickW{1'b1}} : dl_sum[TickW-1:0];
    end
    if (cmd_i.insert) begin
      for (int i = 0; i < MaxSleepers; i++) begin
        if (!le[i]) begin
          if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
            entry_dl_q[i] <= deadline_q;
            entry_id_q[i] <= req_id_q;
          end else begin
            entry_dl_q[i] <= entry_dl_q[(i == 0) ? 0 : i - 1];
            entry_id_q[i] <= entry_id_q[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end else if (cmd_i.pop_emit) begin
      for (int i = 0; i < MaxSleepers - 1; i++) begin
        entry_dl_q[i] <= entry_dl_q[i + 1];
        entry_id_q[i] <= entry_id_q[i + 1];
      end
    end
    if (cmd_i.pop_emit) begin
      out_kind_o <= KindWoken;
      out_id_o   <= entry_id_q[0];
      out_tick_o <= tick_q;
      out_last_o <= status_o.last_pop;
    end else if (cmd_i.reject_emit) begin
      out_kind_o <= KindReject;
      out_id_o   <= req_id_q;
      out_tick_o <= tick_q;
      out_last_o <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> hw/rtl/sorted_sleep_wakeup_queue_core.sv
// Sorted sleep/wake-up queue: tick counter plus deadline-ordered sleeper queue.
// After a sleep request is accepted, the next word waits for the deadline add and the
// shift-insert. A tick increments the counter, then pops due sleepers one at a time, up
// to MaxResults per tick, each pop waiting for a free output register; after a rejected
// request, the next word waits until the reject report enters the free output register.
// Throughput is one item at a time, set by the controller sequence over the shared queue.
// Reset clears the tick counter, the queue count and the output valid flag at once.
`default_nettype none
module sorted_sleep_wakeup_queue_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sswq_in_if.sink   in_i,
  sswq_out_if.source out_o
);
  import sswq_pkg::*;

  sswq_cmd_t    cmd;
  sswq_status_t status;
  logic         in_ready;

  sswq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sswq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_id_i    (in_i.sleeper_id),
    .req_dur_i   (in_i.sleep_ticks),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_kind_o  (out_o.kind),
    .out_id_o    (out_o.woken_id),
    .out_tick_o  (out_o.tick_now),
    .out_last_o  (out_o.last)
  );

  assign in_i.ready = in_ready;

endmodule
`default_nettype wire
